>>> rtl/gradient_pixel_color_assert.svh
// assertion macros for the gradient pixel colour block
`ifndef GRADIENT_PIXEL_COLOR_ASSERT_SVH
`define GRADIENT_PIXEL_COLOR_ASSERT_SVH

// same-cycle implication under reset
`define GPC_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gpc assertion failed");

// next-cycle implication under reset
`define GPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gpc assertion failed");

`endif

>>> rtl/gpc_pkg.sv
// shared constants, types and codes for the gradient pixel colour block
`timescale 1ns / 1ps
`default_nettype none

package gpc_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    localparam int CFG_W      = 24;
    localparam int REG_IDX_W  = 3;
    localparam int DIV_W      = 2 * COORD_BITS + 1;
    localparam int MAG_W      = COORD_BITS + 2;
    localparam int PROD_W     = 2 * COORD_BITS + 2;

    localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

    localparam logic [COORD_BITS-1:0] MAX_X_RST = COORD_BITS'(63);
    localparam logic [COORD_BITS-1:0] MAX_Y_RST = COORD_BITS'(31);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_RGB,
        REG_END_RGB,
        REG_BOX_MIN_X,
        REG_BOX_MIN_Y,
        REG_BOX_MAX_X,
        REG_BOX_MAX_Y,
        REG_DIRECTION,
        REG_EASING
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_HORIZ,
        DIR_VERT,
        DIR_DIAG,
        DIR_RADIAL
    } dir_t;

    typedef enum logic [1:0] {
        EASE_LIN,
        EASE_IN_SQ,
        EASE_OUT_SQ,
        EASE_IN_OUT_SQ
    } ease_t;

    // how a divider lane result is to be taken
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_QUOT
    } sel_t;

    typedef struct packed {
        sel_t sel_a;
        sel_t sel_b;
    } div_side_t;

endpackage

`default_nettype wire

>>> rtl/gpc_if.sv
// stream interfaces for pixel coordinates and colour results
`timescale 1ns / 1ps
`default_nettype none

interface gpc_pix_if;
    logic                          valid;
    logic                          ready;
    logic [gpc_pkg::COORD_BITS-1:0] pixel_x;
    logic [gpc_pkg::COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gpc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> rtl/gpc_frac_div.sv
// pipelined fractional divider, one quotient bit per stage, numerator below divisor
`timescale 1ns / 1ps
`default_nettype none

module gpc_frac_div (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [gpc_pkg::DIV_W-1:0]     num,
    input  wire logic [gpc_pkg::DIV_W-1:0]     den,
    output logic      [gpc_pkg::FRAC_BITS-1:0] quot
);
    import gpc_pkg::*;

    localparam int DW = DIV_W;
    localparam int FB = FRAC_BITS;

    logic [DW-1:0] rem_reg [FB];
    logic [DW-1:0] den_reg [FB];
    logic [FB-1:0] q_reg   [FB];

    genvar i;
    generate
        for (i = 0; i < FB; i++)
        begin : g_stage
            logic [DW-1:0] rin;
            logic [DW-1:0] din;
            logic [FB-1:0] qin;
            logic [DW:0]   r2;
            logic          ge;

            // stage operands
            if (i == 0)
            begin : g_first
                assign rin = num;
                assign din = den;
                assign qin = '0;
            end
            else
            begin : g_rest
                assign rin = rem_reg[i-1];
                assign din = den_reg[i-1];
                assign qin = q_reg[i-1];
            end

            // shift, trial subtract
            assign r2 = {rin, 1'b0};
            assign ge = (r2 >= {1'b0, din});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? DW'(r2 - {1'b0, din}) : r2[DW-1:0];
                    den_reg[i] <= din;
                    q_reg[i]   <= {qin[FB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quot = q_reg[FB-1];

endmodule

`default_nettype wire

>>> rtl/gpc_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module gpc_isqrt (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [2*gpc_pkg::FRAC_BITS-1:0] radicand,
    output logic      [gpc_pkg::FRAC_BITS-1:0]   root
);
    import gpc_pkg::*;

    localparam int FB = FRAC_BITS;

    logic [FB+1:0] rem_reg  [FB];
    logic [FB-1:0] root_reg [FB];
    logic [2*FB-1:0] v_reg  [FB];

    genvar i;
    generate
        for (i = 0; i < FB; i++)
        begin : g_stage
            logic [FB+1:0]   rin;
            logic [FB-1:0]   root_in;
            logic [2*FB-1:0] v_in;
            logic [FB+1:0]   cur;
            logic [FB+1:0]   trial;
            logic            ge;

            if (i == 0)
            begin : g_first
                assign rin     = '0;
                assign root_in = '0;
                assign v_in    = radicand;
            end
            else
            begin : g_rest
                assign rin     = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign v_in    = v_reg[i-1];
            end

            // bring down two bits, try root*4+1
            assign cur   = {rin[FB-1:0], v_in[2*FB-1 -: 2]};
            assign trial = {root_in, 2'b01};
            assign ge    = (cur >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= ge ? (cur - trial) : cur;
                    root_reg[i] <= {root_in[FB-2:0], ge};
                    v_reg[i]    <= {v_in[2*FB-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[FB-1];

endmodule

`default_nettype wire

>>> rtl/gradient_pixel_color.sv
// top level: pipelined two-colour gradient with easing, one pixel per clock while results are taken
//
//  channel  | role   | payload
//  ---------+--------+------------------------------
//  pixel    | sink   | pixel_x, pixel_y
//  color    | source | red, green, blue
//  cfg_*    | write  | cfg_index selects, cfg_data
//
// one pixel per clock sustained while results are taken; the pipeline depth is set by the
// bit-per-stage divider and square root pipelines.
// asynchronous reset clears valid bits and sets configuration to its defaults, no clearing pass.
// a stalled result freezes the whole pipeline in place: nothing lost or repeated,
// and pixel.ready drops only while a result waits untaken.
`timescale 1ns / 1ps
`default_nettype none

module gradient_pixel_color (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gpc_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [gpc_pkg::CFG_W-1:0]     cfg_data,
    gpc_pix_if.sink                            pixel,
    gpc_rgb_if.source                          color
);
    import gpc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int DW = DIV_W;

    // configuration registers
    logic [23:0]   start_rgb_reg;
    logic [23:0]   end_rgb_reg;
    logic [CW-1:0] min_x_reg;
    logic [CW-1:0] min_y_reg;
    logic [CW-1:0] max_x_reg;
    logic [CW-1:0] max_y_reg;
    dir_t          dir_reg;
    ease_t         ease_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rgb_reg <= '0;
            end_rgb_reg   <= 24'hFFFFFF;
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            max_x_reg     <= MAX_X_RST;
            max_y_reg     <= MAX_Y_RST;
            dir_reg       <= DIR_HORIZ;
            ease_reg      <= EASE_LIN;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_START_RGB: start_rgb_reg <= cfg_data[23:0];
                REG_END_RGB:   end_rgb_reg   <= cfg_data[23:0];
                REG_BOX_MIN_X: min_x_reg     <= cfg_data[CW-1:0];
                REG_BOX_MIN_Y: min_y_reg     <= cfg_data[CW-1:0];
                REG_BOX_MAX_X: max_x_reg     <= cfg_data[CW-1:0];
                REG_BOX_MAX_Y: max_y_reg     <= cfg_data[CW-1:0];
                REG_DIRECTION: dir_reg       <= dir_t'(cfg_data[1:0]);
                REG_EASING:    ease_reg      <= ease_t'(cfg_data[1:0]);
                default:       ;
            endcase
        end
    end

    // box terms derived from configuration and registered
    logic [CW-1:0]   w_reg;
    logic [CW-1:0]   h_reg;
    logic            degen_reg;
    logic [DW-1:0]   den_wh_reg;
    logic            radial_reg;
    logic [2*CW-1:0] wh_c;

    assign wh_c = (2*CW)'(w_reg) * (2*CW)'(h_reg);

    always_ff @(posedge clk)
    begin
        w_reg      <= max_x_reg - min_x_reg;
        h_reg      <= max_y_reg - min_y_reg;
        degen_reg  <= (max_x_reg <= min_x_reg) || (max_y_reg <= min_y_reg);
        den_wh_reg <= {wh_c, 1'b0};
        radial_reg <= (dir_reg == DIR_RADIAL) && !((max_x_reg <= min_x_reg)
                      || (max_y_reg <= min_y_reg));
    end

    // global advance: the pipeline moves unless a result waits untaken
    logic color_valid_reg;
    logic advance;

    assign advance     = !color_valid_reg || color.ready;
    assign pixel.ready = advance;

    // stage 1: capture coordinates
    logic          s1_valid_reg;
    logic [CW-1:0] s1_x_reg;
    logic [CW-1:0] s1_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg <= pixel.pixel_x;
            s1_y_reg <= pixel.pixel_y;
        end
    end

    // stage 2: offsets from the box corner and from the box centre
    logic signed [CW:0]   dx_c;
    logic signed [CW:0]   dy_c;
    logic signed [CW+2:0] ax_c;
    logic signed [CW+2:0] ay_c;
    logic signed [CW+2:0] mx_c;
    logic signed [CW+2:0] my_c;

    assign dx_c = $signed({1'b0, s1_x_reg}) - $signed({1'b0, min_x_reg});
    assign dy_c = $signed({1'b0, s1_y_reg}) - $signed({1'b0, min_y_reg});
    assign ax_c = $signed({dx_c[CW], dx_c, 1'b0}) - $signed({3'b000, w_reg});
    assign ay_c = $signed({dy_c[CW], dy_c, 1'b0}) - $signed({3'b000, h_reg});
    assign mx_c = ax_c[CW+2] ? -ax_c : ax_c;
    assign my_c = ay_c[CW+2] ? -ay_c : ay_c;

    logic               s2_valid_reg;
    logic signed [CW:0] s2_dx_reg;
    logic signed [CW:0] s2_dy_reg;
    logic [MAG_W-1:0]   s2_mx_reg;
    logic [MAG_W-1:0]   s2_my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (advance)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_dx_reg <= dx_c;
            s2_dy_reg <= dy_c;
            s2_mx_reg <= mx_c[MAG_W-1:0];
            s2_my_reg <= my_c[MAG_W-1:0];
        end
    end

    // stage 3: cross products for the diagonal
    logic                    s3_valid_reg;
    logic signed [CW:0]      s3_dx_reg;
    logic signed [CW:0]      s3_dy_reg;
    logic [MAG_W-1:0]        s3_mx_reg;
    logic [MAG_W-1:0]        s3_my_reg;
    logic signed [PROD_W-1:0] s3_pdx_reg;
    logic signed [PROD_W-1:0] s3_pdy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (advance)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_mx_reg  <= s2_mx_reg;
            s3_my_reg  <= s2_my_reg;
            s3_pdx_reg <= s2_dx_reg * $signed({1'b0, h_reg});
            s3_pdy_reg <= s2_dy_reg * $signed({1'b0, w_reg});
        end
    end

    // stage 4: pick numerator and divisor, settle the clamped cases
    logic signed [PROD_W:0] sum_c;
    logic [DW-1:0]          a_num_c;
    logic [DW-1:0]          a_den_c;
    logic [DW-1:0]          b_num_c;
    logic [DW-1:0]          b_den_c;
    div_side_t              side_c;

    assign sum_c = s3_pdx_reg + s3_pdy_reg;

    always_comb
    begin
        a_num_c      = '0;
        a_den_c      = DW'(w_reg);
        b_num_c      = '0;
        b_den_c      = DW'(h_reg);
        side_c.sel_a = SEL_ZERO;
        side_c.sel_b = SEL_ZERO;
        if (!degen_reg)
        begin
            case (dir_reg)
                DIR_HORIZ:
                begin
                    a_num_c = DW'($unsigned(s3_dx_reg));
                    a_den_c = DW'(w_reg);
                    if (s3_dx_reg <= 0)
                        side_c.sel_a = SEL_ZERO;
                    else if (s3_dx_reg >= $signed({1'b0, w_reg}))
                        side_c.sel_a = SEL_ONE;
                    else
                        side_c.sel_a = SEL_QUOT;
                end
                DIR_VERT:
                begin
                    a_num_c = DW'($unsigned(s3_dy_reg));
                    a_den_c = DW'(h_reg);
                    if (s3_dy_reg <= 0)
                        side_c.sel_a = SEL_ZERO;
                    else if (s3_dy_reg >= $signed({1'b0, h_reg}))
                        side_c.sel_a = SEL_ONE;
                    else
                        side_c.sel_a = SEL_QUOT;
                end
                DIR_DIAG:
                begin
                    a_num_c = DW'($unsigned(sum_c));
                    a_den_c = den_wh_reg;
                    if (sum_c <= 0)
                        side_c.sel_a = SEL_ZERO;
                    else if (sum_c >= $signed({2'b00, den_wh_reg}))
                        side_c.sel_a = SEL_ONE;
                    else
                        side_c.sel_a = SEL_QUOT;
                end
                default:
                begin
                    a_num_c      = DW'(s3_mx_reg);
                    a_den_c      = DW'({w_reg, 1'b0});
                    b_num_c      = DW'(s3_my_reg);
                    b_den_c      = DW'({h_reg, 1'b0});
                    side_c.sel_a = (s3_mx_reg >= {1'b0, w_reg, 1'b0}) ? SEL_ONE : SEL_QUOT;
                    side_c.sel_b = (s3_my_reg >= {1'b0, h_reg, 1'b0}) ? SEL_ONE : SEL_QUOT;
                end
            endcase
        end
    end

    logic          s4_valid_reg;
    logic [DW-1:0] s4_a_num_reg;
    logic [DW-1:0] s4_a_den_reg;
    logic [DW-1:0] s4_b_num_reg;
    logic [DW-1:0] s4_b_den_reg;
    div_side_t     s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (advance)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_a_num_reg <= a_num_c;
            s4_a_den_reg <= a_den_c;
            s4_b_num_reg <= b_num_c;
            s4_b_den_reg <= b_den_c;
            s4_side_reg  <= side_c;
        end
    end

    // divider lanes: the single axis, the diagonal sum or radial x in lane a, radial y in lane b
    logic [FB-1:0] quot_a;
    logic [FB-1:0] quot_b;

    gpc_frac_div u_div_a (
        .clk  (clk),
        .en   (advance),
        .num  (s4_a_num_reg),
        .den  (s4_a_den_reg),
        .quot (quot_a)
    );

    gpc_frac_div u_div_b (
        .clk  (clk),
        .en   (advance),
        .num  (s4_b_num_reg),
        .den  (s4_b_den_reg),
        .quot (quot_b)
    );

    // sideband alongside the dividers
    logic [FB-1:0] dv_valid_reg;
    div_side_t     dv_side_reg [FB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else if (advance)
            dv_valid_reg <= {dv_valid_reg[FB-2:0], s4_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_side_reg[0] <= s4_side_reg;
            for (int i = 1; i < FB; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // stage 5: lane factors and their squares
    logic [FB:0] qa_c;
    logic [FB:0] qb_c;

    always_comb
    begin
        case (dv_side_reg[FB-1].sel_a)
            SEL_ONE:  qa_c = ONE;
            SEL_QUOT: qa_c = {1'b0, quot_a};
            default:  qa_c = '0;
        endcase
        case (dv_side_reg[FB-1].sel_b)
            SEL_ONE:  qb_c = ONE;
            SEL_QUOT: qb_c = {1'b0, quot_b};
            default:  qb_c = '0;
        endcase
    end

    logic              s5_valid_reg;
    logic [FB:0]       s5_t_reg;
    logic [2*FB+1:0]   s5_sqa_reg;
    logic [2*FB+1:0]   s5_sqb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (advance)
            s5_valid_reg <= dv_valid_reg[FB-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s5_t_reg   <= qa_c;
            s5_sqa_reg <= qa_c * qa_c;
            s5_sqb_reg <= qb_c * qb_c;
        end
    end

    // stage 6: radicand 2*(qx^2 + qy^2) and saturation at or above one squared
    logic [2*FB+3:0] rad_c;

    assign rad_c = ({2'b00, s5_sqa_reg} + {2'b00, s5_sqb_reg}) << 1;

    logic            s6_valid_reg;
    logic [FB:0]     s6_t_reg;
    logic            s6_sat_reg;
    logic [2*FB-1:0] s6_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (advance)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_t_reg   <= s5_t_reg;
            s6_sat_reg <= |rad_c[2*FB+3:2*FB];
            s6_rad_reg <= rad_c[2*FB-1:0];
        end
    end

    logic [FB-1:0] root;

    gpc_isqrt u_sqrt (
        .clk      (clk),
        .en       (advance),
        .radicand (s6_rad_reg),
        .root     (root)
    );

    // sideband alongside the square root
    logic [FB-1:0] sq_valid_reg;
    logic [FB-1:0] sq_sat_reg;
    logic [FB:0]   sq_t_reg [FB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= '0;
        else if (advance)
            sq_valid_reg <= {sq_valid_reg[FB-2:0], s6_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_sat_reg  <= {sq_sat_reg[FB-2:0], s6_sat_reg};
            sq_t_reg[0] <= s6_t_reg;
            for (int i = 1; i < FB; i++)
                sq_t_reg[i] <= sq_t_reg[i-1];
        end
    end

    // stage 7: final gradient factor
    logic [FB:0] factor_c;

    always_comb
    begin
        if (!radial_reg)
            factor_c = sq_t_reg[FB-1];
        else if (sq_sat_reg[FB-1])
            factor_c = ONE;
        else
            factor_c = {1'b0, root};
    end

    logic        s7_valid_reg;
    logic [FB:0] s7_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (advance)
            s7_valid_reg <= sq_valid_reg[FB-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s7_t_reg <= factor_c;
    end

    // stage 8: easing square of t or of one minus t
    logic [FB:0] u_c;

    always_comb
    begin
        case (ease_reg)
            EASE_OUT_SQ:    u_c = ONE - s7_t_reg;
            EASE_IN_OUT_SQ: u_c = (s7_t_reg < HALF) ? s7_t_reg : (ONE - s7_t_reg);
            default:        u_c = s7_t_reg;
        endcase
    end

    logic            s8_valid_reg;
    logic [FB:0]     s8_t_reg;
    logic [2*FB+1:0] s8_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_valid_reg <= 1'b0;
        else if (advance)
            s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s8_t_reg  <= s7_t_reg;
            s8_sq_reg <= u_c * u_c;
        end
    end

    // stage 9: eased factor
    logic [FB:0] eased_c;

    always_comb
    begin
        case (ease_reg)
            EASE_IN_SQ:  eased_c = s8_sq_reg[2*FB:FB];
            EASE_OUT_SQ: eased_c = ONE - s8_sq_reg[2*FB:FB];
            EASE_IN_OUT_SQ:
            begin
                if (s8_t_reg < HALF)
                    eased_c = s8_sq_reg[2*FB-1:FB-1];
                else
                    eased_c = ONE - s8_sq_reg[2*FB-1:FB-1];
            end
            default:     eased_c = s8_t_reg;
        endcase
    end

    logic        s9_valid_reg;
    logic [FB:0] s9_te_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_valid_reg <= 1'b0;
        else if (advance)
            s9_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s9_te_reg <= eased_c;
    end

    // stage 10: colour step products, one per channel (byte 2 red .. byte 0 blue)
    logic          s10_valid_reg;
    logic [2:0]    s10_up_reg;
    logic [FB+8:0] s10_prod_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_valid_reg <= 1'b0;
        else if (advance)
            s10_valid_reg <= s9_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (end_rgb_reg[8*c +: 8] >= start_rgb_reg[8*c +: 8])
                begin
                    s10_up_reg[c]   <= 1'b1;
                    s10_prod_reg[c] <= (end_rgb_reg[8*c +: 8] - start_rgb_reg[8*c +: 8])
                                       * s9_te_reg;
                end
                else
                begin
                    s10_up_reg[c]   <= 1'b0;
                    s10_prod_reg[c] <= (start_rgb_reg[8*c +: 8] - end_rgb_reg[8*c +: 8])
                                       * s9_te_reg;
                end
            end
        end
    end

    // stage 11: result register, channel values rounded down
    logic [7:0]    chan_c [3];
    logic [FB+8:0] ceil_c [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ceil_c[c] = s10_prod_reg[c] + {9'b0, {FB{1'b1}}};
            if (s10_up_reg[c])
                chan_c[c] = start_rgb_reg[8*c +: 8] + s10_prod_reg[c][FB+7:FB];
            else
                chan_c[c] = start_rgb_reg[8*c +: 8] - ceil_c[c][FB+7:FB];
        end
    end

    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_valid_reg <= 1'b0;
        else if (advance)
            color_valid_reg <= s10_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= chan_c[2];
            green_reg <= chan_c[1];
            blue_reg  <= chan_c[0];
        end
    end

    assign color.valid = color_valid_reg;
    assign color.red   = red_reg;
    assign color.green = green_reg;
    assign color.blue  = blue_reg;

endmodule

`default_nettype wire

>>> rtl/gpc_checker.sv
// port-level checker for the gradient pixel colour block, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "gradient_pixel_color_assert.svh"

module gpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] out_data
);
    logic in_seen;
    logic out_stall;

    assign in_seen   = in_valid || !in_valid;
    assign out_stall = out_valid && !out_ready;

    // a waiting result stays offered and holds its colour
    `GPC_ASSERT_NEXT(a_out_hold_valid, clk, rst_n, out_stall, out_valid)
    `GPC_ASSERT_NEXT(a_out_hold_data, clk, rst_n, out_stall, $stable(out_data))

    // the pipeline freezes only behind a waiting result
    `GPC_ASSERT_NOW(a_in_block_on_stall, clk, rst_n, out_stall && in_seen, !in_ready)
    `GPC_ASSERT_NOW(a_in_open_when_free, clk, rst_n, !out_valid || out_ready, in_ready)

endmodule

bind gradient_pixel_color gpc_checker u_gpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (color.valid),
    .out_ready (color.ready),
    .out_data  ({color.red, color.green, color.blue})
);

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the gradient pixel colour block
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import gpc_pkg::*;

    localparam int LATENCY   = 2 * FRAC_BITS + 11;
    localparam int IDLE_MAX  = 5000;
    localparam longint UNIT  = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // one row of the directed table: coordinate, expected colour if known
    typedef struct {
        int   x;
        int   y;
        bit   known;
        rgb_t colour;
    } pix_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gpc_pix_if pixel ();
    gpc_rgb_if color ();

    gradient_pixel_color u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel.sink),
        .color     (color.source)
    );

    // shadow of the configuration registers
    logic [23:0] sh_start, sh_end;
    logic [COORD_BITS-1:0] sh_min_x, sh_min_y, sh_max_x, sh_max_y;
    dir_t  sh_dir;
    ease_t sh_ease;

    rgb_t colour_q[$];
    bit   failed;
    int   idle_cycles;
    bit   rx_busy_ok;
    int   rx_hold;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint unsigned ratio_clamped(longint num, longint unsigned den);
        longint unsigned q;
        if (num <= 0) return 0;
        q = (longint'(num) * UNIT) / den;
        return (q > UNIT) ? UNIT : q;
    endfunction

    function automatic longint unsigned centre_offset(longint d, longint size);
        longint a;
        longint unsigned mag, q;
        a = 2 * d - size;
        mag = (a < 0) ? -a : a;
        q = (mag * UNIT) / (2 * size);
        return (q > UNIT) ? UNIT : q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v)
                r = r | (64'd1 << b);
        end
        return r;
    endfunction

    function automatic longint unsigned shade(int px, int py);
        longint w, h, dx, dy;
        longint unsigned qx, qy, r;
        if (sh_max_x <= sh_min_x || sh_max_y <= sh_min_y) return 0;
        w  = longint'(sh_max_x) - longint'(sh_min_x);
        h  = longint'(sh_max_y) - longint'(sh_min_y);
        dx = longint'(px) - longint'(sh_min_x);
        dy = longint'(py) - longint'(sh_min_y);
        case (sh_dir)
            DIR_HORIZ: return ratio_clamped(dx, w);
            DIR_VERT:  return ratio_clamped(dy, h);
            DIR_DIAG:  return ratio_clamped(dx * h + dy * w, 2 * w * h);
            default:
            begin
                qx = centre_offset(dx, w);
                qy = centre_offset(dy, h);
                r  = int_sqrt(2 * (qx * qx + qy * qy));
                return (r > UNIT) ? UNIT : r;
            end
        endcase
    endfunction

    function automatic longint unsigned eased(longint unsigned t);
        longint unsigned f;
        f = UNIT - t;
        case (sh_ease)
            EASE_LIN:    return t;
            EASE_IN_SQ:  return (t * t) >> FRAC_BITS;
            EASE_OUT_SQ: return UNIT - ((f * f) >> FRAC_BITS);
            default:
            begin
                if (t < UNIT / 2) return (2 * t * t) >> FRAC_BITS;
                return UNIT - ((2 * f * f) >> FRAC_BITS);
            end
        endcase
    endfunction

    function automatic logic [7:0] mix(logic [7:0] s, logic [7:0] e, longint unsigned t);
        longint unsigned d;
        if (e >= s) begin
            d = longint'(e - s) * t;
            return 8'(longint'(s) + (d >> FRAC_BITS));
        end
        d = longint'(s - e) * t;
        return 8'(longint'(s) - ((d + UNIT - 1) >> FRAC_BITS));
    endfunction

    function automatic rgb_t pixel_colour(int px, int py);
        longint unsigned t;
        rgb_t c;
        t = eased(shade(px, py));
        c.red   = mix(sh_start[23:16], sh_end[23:16], t);
        c.green = mix(sh_start[15:8],  sh_end[15:8],  t);
        c.blue  = mix(sh_start[7:0],   sh_end[7:0],   t);
        return c;
    endfunction

    // register write, also updating the shadow copy
    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_START_RGB: sh_start = data;
            REG_END_RGB:   sh_end   = data;
            REG_BOX_MIN_X: sh_min_x = data[COORD_BITS-1:0];
            REG_BOX_MIN_Y: sh_min_y = data[COORD_BITS-1:0];
            REG_BOX_MAX_X: sh_max_x = data[COORD_BITS-1:0];
            REG_BOX_MAX_Y: sh_max_y = data[COORD_BITS-1:0];
            REG_DIRECTION: sh_dir   = dir_t'(data[1:0]);
            REG_EASING:    sh_ease  = ease_t'(data[1:0]);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [23:0] s, logic [23:0] e, int x0, int y0, int x1,
                             int y1, dir_t d, ease_t m);
        write_reg(REG_START_RGB, s);
        write_reg(REG_END_RGB, e);
        write_reg(REG_BOX_MIN_X, CFG_W'(x0));
        write_reg(REG_BOX_MIN_Y, CFG_W'(y0));
        write_reg(REG_BOX_MAX_X, CFG_W'(x1));
        write_reg(REG_BOX_MAX_Y, CFG_W'(y1));
        write_reg(REG_DIRECTION, CFG_W'(d));
        write_reg(REG_EASING, CFG_W'(m));
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // send one pixel transaction, queueing its colour
    task automatic send_pixel(int px, int py, bit known, rgb_t want);
        rgb_t c;
        int   gap;
        c = known ? want : pixel_colour(px, py);
        if (known && want != pixel_colour(px, py)) begin
            $error("table row (%0d,%0d) disagrees with predictor", px, py);
            failed = 1'b1;
        end
        pixel.valid   <= 1'b1;
        pixel.pixel_x <= COORD_BITS'(px);
        pixel.pixel_y <= COORD_BITS'(py);
        do @(posedge clk); while (!pixel.ready);
        colour_q.push_back(c);
        @(negedge clk);
        // valid stays high into a back-to-back transaction
        gap = gap_len();
        if (gap > 0)
        begin
            pixel.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        pixel.valid <= 1'b0;
        while (colour_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // sink side: random back-pressure, now and then a long stall
    always @(negedge clk)
    begin
        if (!rst_n)
            color.ready <= 1'b0;
        else if (!rx_busy_ok)
            color.ready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold     = rx_hold - 1;
            color.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            rx_hold     = $urandom_range(8, 30);
            color.ready <= 1'b0;
        end
        else
            color.ready <= ($urandom_range(0, 99) < 70);
    end

    // result checker
    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n && color.valid && color.ready) begin
            if (colour_q.size() == 0) begin
                $error("colour transaction with nothing expected");
                failed = 1'b1;
            end
            else begin
                want = colour_q.pop_front();
                if (color.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, color.red);
                    failed = 1'b1;
                end
                if (color.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, color.green);
                    failed = 1'b1;
                end
                if (color.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, color.blue);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((pixel.valid && pixel.ready) || (color.valid && color.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    pix_row_t table_rows[] = '{
        '{0,    0,  1, '{8'h00, 8'h00, 8'h00}},
        '{63,   0,  1, '{8'hff, 8'hff, 8'hff}},
        '{1023, 1023, 1, '{8'hff, 8'hff, 8'hff}},
        '{32,   5,  0, '{8'h00, 8'h00, 8'h00}},
        '{31,   31, 0, '{8'h00, 8'h00, 8'h00}},
        '{682,  341, 0, '{8'h00, 8'h00, 8'h00}}
    };

    // coordinates swept through each direction configuration of the directed part
    int sweep_x[] = '{0, 10, 50, 100, 150, 200, 1023, 341, 682, 5};
    int sweep_y[] = '{0, 20, 60, 90, 120, 1023, 150, 341, 682, 7};

    initial
    begin
        int n_rand;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pixel.valid   = 1'b0;
        pixel.pixel_x = '0;
        pixel.pixel_y = '0;
        color.ready   = 1'b0;
        failed        = 1'b0;
        idle_cycles   = 0;
        rx_busy_ok    = 1'b0;
        sh_start = 24'h000000; sh_end = 24'hffffff;
        sh_min_x = '0; sh_min_y = '0; sh_max_x = MAX_X_RST; sh_max_y = MAX_Y_RST;
        sh_dir = DIR_HORIZ; sh_ease = EASE_LIN;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values
        foreach (table_rows[i])
            send_pixel(table_rows[i].x, table_rows[i].y, table_rows[i].known,
                       table_rows[i].colour);
        drain();

        // each direction paired with one easing, red falling while green and blue rise
        for (int d = 0; d < 4; d++) begin
            write_all(24'hff8001, 24'h00ff80, 50, 20, 150, 120, dir_t'(d), ease_t'(d));
            foreach (sweep_x[i]) send_pixel(sweep_x[i], sweep_y[i], 0, '0);
            drain();
        end

        // degenerate box gives the start colour
        write_all(24'h123456, 24'hfedcba, 100, 100, 100, 200, DIR_RADIAL, EASE_OUT_SQ);
        send_pixel(150, 150, 1, '{8'h12, 8'h34, 8'h56});
        send_pixel(1023, 0, 1, '{8'h12, 8'h34, 8'h56});
        drain();

        // random phases with back-pressure
        rx_busy_ok = 1'b1;
        n_rand = 0;
        while (n_rand < 450) begin
            int x0, y0, x1, y1;
            x0 = $urandom_range(0, 1023); x1 = $urandom_range(0, 1023);
            y0 = $urandom_range(0, 1023); y1 = $urandom_range(0, 1023);
            if ($urandom_range(0, 9) < 8) begin
                if (x0 > x1) begin int t; t = x0; x0 = x1; x1 = t; end
                if (y0 > y1) begin int t; t = y0; y0 = y1; y1 = t; end
            end
            if ($urandom_range(0, 7) == 0) begin x0 = 0; x1 = 1023; y0 = 0; y1 = 1023; end
            if ($urandom_range(0, 7) == 0) begin x0 = 500; x1 = 501; y0 = 7; y1 = 8; end
            write_all(24'($urandom_range(0, 24'hffffff)), 24'($urandom_range(0, 24'hffffff)),
                      x0, y0, x1, y1, dir_t'($urandom_range(0, 3)),
                      ease_t'($urandom_range(0, 3)));
            for (int k = 0; k < 30; k++) begin
                int px, py;
                if ($urandom_range(0, 4) != 0 && x1 > x0 && y1 > y0) begin
                    px = $urandom_range(x0, x1);
                    py = $urandom_range(y0, y1);
                end
                else begin
                    px = $urandom_range(0, 1023);
                    py = $urandom_range(0, 1023);
                end
                send_pixel(px, py, 0, '0);
                n_rand++;
            end
            drain();
        end

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/gpc_pkg.sv
rtl/gpc_if.sv
rtl/gpc_frac_div.sv
rtl/gpc_isqrt.sv
rtl/gradient_pixel_color.sv
rtl/gpc_checker.sv
dv/tb_top.sv
